// File: design/pal_pkg.sv
// Shared constants, codes and types of the positional array list.
package pal_pkg;

    // list geometry
    localparam int CAPACITY      = 128;
    localparam int ELEMENT_WIDTH = 32;
    localparam int IDX_W         = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    // item field widths
    localparam int CMD_W   = 3;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STS_W   = 2;
    localparam int COUNT_W = 8;
    localparam int RD_W    = 32;

    // width that holds both a position and a count for compares
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // read-back OR tree: cells per group, groups
    localparam int GRP_SIZE = 16;
    localparam int GRP_NUM  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    typedef logic [ELEMENT_WIDTH-1:0] t_elem;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_ERASE      = 3'd5,
        CMD_READ       = 3'd6
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_RUN  = 1'b0,
        S_READ = 1'b1
    } t_state;

    // broadcast to every cell
    typedef struct packed {
        logic open_slot;   // cells above at take the left neighbor, cell at takes value
        logic close_slot;  // cells from at upward take the right neighbor
        logic rd_en;       // cell at drives its word onto the read tree
        t_idx at;
    } t_cell_ctl;

endpackage

// File: design/pal_cmd_if.sv
// Command channel: valid/ready with the command item payload.
interface pal_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [pal_pkg::CMD_W-1:0] command;
    logic [pal_pkg::POS_W-1:0] position;
    logic [pal_pkg::VAL_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

// File: design/pal_rsp_if.sv
// Response channel: valid/ready with the result item payload.
interface pal_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pal_pkg::STS_W-1:0]   status;
    logic [pal_pkg::COUNT_W-1:0] count;
    logic [pal_pkg::RD_W-1:0]    read_value;

    modport source (output valid, status, count, read_value, input ready);
    modport sink   (input valid, status, count, read_value, output ready);
endinterface

// File: design/pal_cell.sv
// One list slot: holds a word and shifts it with its neighbors.
module pal_cell (
    input  logic               i_clk,
    input  pal_pkg::t_cell_ctl i_ctl,
    input  pal_pkg::t_elem     i_value,
    input  pal_pkg::t_idx      i_index,
    input  pal_pkg::t_elem     i_left,
    input  pal_pkg::t_elem     i_right,
    output pal_pkg::t_elem     o_data,
    output pal_pkg::t_elem     o_rd
);
    import pal_pkg::*;

    t_elem r_data;
    t_elem n_data;

    always_comb begin
        priority if (i_ctl.open_slot && (i_index > i_ctl.at)) begin
            n_data = i_left;
        end else if (i_ctl.open_slot && (i_index == i_ctl.at)) begin
            n_data = i_value;
        end else if (i_ctl.close_slot && (i_index >= i_ctl.at)) begin
            n_data = i_right;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (i_ctl.rd_en && (i_index == i_ctl.at)) ? r_data : '0;

endmodule

// File: design/pal_ctrl.sv
// Command decode, status checks and the element count register.
module pal_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [pal_pkg::CMD_W-1:0] i_command,
    input  logic [pal_pkg::POS_W-1:0] i_position,
    output pal_pkg::t_cell_ctl        o_ctl,
    output pal_pkg::t_status          o_status,
    output pal_pkg::t_cnt             o_next_count,
    output pal_pkg::t_cnt             o_count,
    output logic                      o_is_read
);
    import pal_pkg::*;

    t_cnt      r_count;
    t_cnt      n_count;
    t_cell_ctl w_ctl;
    t_status   w_status;
    logic      w_full;
    logic      w_empty;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;

    assign w_full  = (r_count >= CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_pos   = CMP_W'(i_position);
    assign w_cnt   = CMP_W'(r_count);

    always_comb begin
        w_ctl    = '0;
        w_status = STS_OK;
        n_count  = r_count;
        unique case (t_cmd'(i_command))
            CMD_PUSH_BACK: begin
                if (w_full) begin
                    w_status = STS_FULL;
                end else begin
                    w_ctl.open_slot = 1'b1;
                    w_ctl.at        = IDX_W'(r_count);
                    n_count         = r_count + CNT_W'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = STS_FULL;
                end else begin
                    w_ctl.open_slot = 1'b1;
                    n_count         = r_count + CNT_W'(1);
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    w_status = STS_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    w_status = STS_EMPTY;
                end else begin
                    w_ctl.close_slot = 1'b1;
                    n_count          = r_count - CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                if (w_full) begin
                    w_status = STS_FULL;
                end else if (w_pos > w_cnt) begin
                    w_status = STS_RANGE;
                end else begin
                    w_ctl.open_slot = 1'b1;
                    w_ctl.at        = IDX_W'(i_position);
                    n_count         = r_count + CNT_W'(1);
                end
            end
            CMD_ERASE: begin
                if (w_empty) begin
                    w_status = STS_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_status = STS_RANGE;
                end else begin
                    w_ctl.close_slot = 1'b1;
                    w_ctl.at         = IDX_W'(i_position);
                    n_count          = r_count - CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (w_empty) begin
                    w_status = STS_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_status = STS_RANGE;
                end else begin
                    w_ctl.rd_en = 1'b1;
                    w_ctl.at    = IDX_W'(i_position);
                end
            end
            default: begin
                // unused code: no change
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    // cells act only on an accepted item
    assign o_ctl.open_slot  = w_ctl.open_slot && i_accept;
    assign o_ctl.close_slot = w_ctl.close_slot && i_accept;
    assign o_ctl.rd_en      = w_ctl.rd_en && i_accept;
    assign o_ctl.at         = w_ctl.at;

    assign o_status     = w_status;
    assign o_next_count = n_count;
    assign o_count      = r_count;
    assign o_is_read    = (t_cmd'(i_command) == CMD_READ);

endmodule

// File: design/positional_array_list_top.sv
// Top level of the positional array list: command decode, cell chain, response register.
//
// An ordered list of up to 128 words held in a row of cells, one word per cell.
// Every command except read is decoded and applied in the cycle it is accepted:
// all cells shift at once, and a new command is accepted every cycle while the
// response side keeps up. For a read the addressed cell drives a registered OR tree
// (groups of 16 cells, then the group results), and no command is accepted while
// the state machine is in S_READ. Failed commands return their status and leave
// the list unchanged. Only the count, the state and the response valid are reset;
// cell contents are undefined until written, which never shows because only
// positions below the count are read.
module positional_array_list_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pal_cmd_if.sink   i_cmd,
    pal_rsp_if.source o_rsp
);
    import pal_pkg::*;

    t_state    r_state;
    t_state    n_state;
    logic      w_acc;
    logic      w_slot_free;
    logic      w_ready;
    t_cell_ctl w_ctl;
    t_status   w_status;
    t_cnt      w_next_count;
    t_cnt      w_count;
    logic      w_is_read;
    t_elem     w_value;

    t_elem     w_data [CAPACITY];
    t_elem     w_rd   [CAPACITY];
    t_elem     w_grp  [GRP_NUM];
    t_elem     r_grp  [GRP_NUM];
    t_elem     w_rd_all;

    logic                 r_out_valid;
    logic [STS_W-1:0]     r_status;
    logic [COUNT_W-1:0]   r_count;
    logic [RD_W-1:0]      r_rdata;

    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_cmd.valid && w_ready;
    assign w_value     = ELEMENT_WIDTH'(i_cmd.value);

    pal_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_acc),
        .i_command    (i_cmd.command),
        .i_position   (i_cmd.position),
        .o_ctl        (w_ctl),
        .o_status     (w_status),
        .o_next_count (w_next_count),
        .o_count      (w_count),
        .o_is_read    (w_is_read)
    );

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_elem w_left;
        t_elem w_right;
        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_data[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_data[gi+1];
        end
        pal_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (w_value),
            .i_index (IDX_W'(gi)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[gi]),
            .o_rd    (w_rd[gi])
        );
    end

    // first level of the read tree: OR within each group
    always_comb begin
        for (int g = 0; g < GRP_NUM; g++) begin
            w_grp[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                if (g * GRP_SIZE + k < CAPACITY) begin
                    w_grp[g] = w_grp[g] | w_rd[g * GRP_SIZE + k];
                end
            end
        end
    end

    // second level: OR of the registered group results
    always_comb begin
        w_rd_all = '0;
        for (int g = 0; g < GRP_NUM; g++) begin
            w_rd_all = w_rd_all | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_is_read) begin
            r_grp <= w_grp;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (w_acc && w_is_read) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_RUN;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        unique case (r_state)
            S_RUN:   w_ready = w_slot_free;
            S_READ:  w_ready = 1'b0;
            default: w_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((w_acc && !w_is_read) || (r_state == S_READ)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload; a read holds valid low until its word arrives
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= w_status;
            r_count  <= COUNT_W'(w_next_count);
            r_rdata  <= '0;
        end else if (r_state == S_READ) begin
            r_rdata <= RD_W'(w_rd_all);
        end
    end

    assign i_cmd.ready      = w_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.count      = r_count;
    assign o_rsp.read_value = r_rdata;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(w_count))
        else $error("element count changed without an accepted item");

    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_is_read) |=> r_out_valid)
        else $error("result missing after an accepted item");

    a_read_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_read) |=> (!w_ready && !r_out_valid))
        else $error("read item not held for its tree cycle");

endmodule

// File: bench/pal_list_checker.sv
`timescale 1ns / 100ps
// Checker for the positional array list: shadow list, awaited results, field compares.
module pal_list_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pal_cmd_if   i_cmd,
    pal_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_list_count
);
    import pal_pkg::*;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic [RD_W-1:0]    read_value;
    } t_list_result;

    t_elem        shadow_elems [CAPACITY];
    int unsigned  shadow_count = 0;
    t_list_result awaited_results [$];
    t_list_result want;
    int           mismatch_total = 0;
    int           result_index = 0;

    assign o_fail_count = mismatch_total;

    task automatic report_mismatch(string msg);
        // keep the log short when everything goes wrong
        if (mismatch_total < 40) begin
            $display("[%0t] list mismatch: %s", $realtime, msg);
        end
        mismatch_total++;
    endtask

    // move entries from 'at' upward one place and store the word at 'at'
    function automatic void shift_in(int unsigned at, logic [VAL_W-1:0] word);
        for (int unsigned i = shadow_count; i > at; i--) begin
            shadow_elems[i] = shadow_elems[i-1];
        end
        shadow_elems[at] = t_elem'(word);
        shadow_count++;
    endfunction

    // drop the entry at 'at' and close the gap
    function automatic void shift_out(int unsigned at);
        for (int unsigned i = at; i + 1 < shadow_count; i++) begin
            shadow_elems[i] = shadow_elems[i+1];
        end
        shadow_count--;
    endfunction

    function automatic t_list_result apply_list_command(logic [CMD_W-1:0] code,
                                                        logic [POS_W-1:0] pos,
                                                        logic [VAL_W-1:0] word);
        t_list_result r;
        logic         full;
        logic         empty;
        full         = shadow_count >= CAPACITY;
        empty        = shadow_count == 0;
        r.status     = STS_OK;
        r.read_value = '0;
        case (code)
            CMD_PUSH_BACK: begin
                if (full) r.status = STS_FULL;
                else shift_in(shadow_count, word);
            end
            CMD_PUSH_FRONT: begin
                if (full) r.status = STS_FULL;
                else shift_in(0, word);
            end
            CMD_POP_BACK: begin
                if (empty) r.status = STS_EMPTY;
                else shadow_count--;
            end
            CMD_POP_FRONT: begin
                if (empty) r.status = STS_EMPTY;
                else shift_out(0);
            end
            CMD_INSERT: begin
                // full wins over a bad position
                if (full) r.status = STS_FULL;
                else if (pos > shadow_count) r.status = STS_RANGE;
                else shift_in(pos, word);
            end
            CMD_ERASE: begin
                if (empty) r.status = STS_EMPTY;
                else if (pos >= shadow_count) r.status = STS_RANGE;
                else shift_out(pos);
            end
            CMD_READ: begin
                if (empty) r.status = STS_EMPTY;
                else if (pos >= shadow_count) r.status = STS_RANGE;
                else r.read_value = RD_W'(shadow_elems[pos]);
            end
            default: begin
                // unused code: list unchanged, plain ok
            end
        endcase
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            // a result cannot belong to a command taken at the same edge
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no command waiting",
                                              result_index));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_rsp.status !== want.status) begin
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  result_index, i_rsp.status, want.status));
                    end
                    if (i_rsp.count !== want.count) begin
                        report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                                  result_index, i_rsp.count, want.count));
                    end
                    if (i_rsp.read_value !== want.read_value) begin
                        report_mismatch($sformatf("result %0d read_value %h, expected %h",
                                                  result_index, i_rsp.read_value,
                                                  want.read_value));
                    end
                end
                result_index++;
            end
            if (i_cmd.valid === 1'b1 && i_cmd.ready === 1'b1) begin
                awaited_results.insert(awaited_results.size(),
                                       apply_list_command(i_cmd.command, i_cmd.position,
                                                          i_cmd.value));
            end
        end
        o_pending    <= awaited_results.size();
        o_list_count <= shadow_count;
    end

endmodule

// File: bench/tb_positional_array_list_top.sv
`timescale 1ns / 100ps
// Testbench top for the positional array list: clock, reset, command stimulus, verdict.
module tb_positional_array_list_top;
    import pal_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int RSP_HOLD_CYCLES = 40;
    localparam int TAIL_CYCLES     = 10;
    localparam int CYCLE_LIMIT     = 100000;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} t_mix;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   list_count;
    int   cycle_count = 0;
    int   hold_ticket = 0;
    bit   sender_idle_en = 1'b1;
    bit   rsp_idle_en = 1'b1;

    pal_cmd_if cmd_ch ();
    pal_rsp_if rsp_ch ();

    positional_array_list_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    pal_list_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_list_count (list_count)
    );

    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold whenever the ticket moves
    initial begin : rsp_side
        int hold_served;
        hold_served = 0;
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if (hold_ticket != hold_served) begin
                hold_served = hold_ticket;
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
            end else if (rsp_idle_en && $urandom_range(0, 2) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // offer one item and hold it until taken; valid stays high afterwards
    task automatic send_item(logic [CMD_W-1:0] code, logic [POS_W-1:0] pos,
                             logic [VAL_W-1:0] word);
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= code;
        cmd_ch.position <= pos;
        cmd_ch.value    <= word;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    endtask

    task automatic hold_sender(int cycles);
        cmd_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // cut[k] is the cumulative percentage bound of op_order[k]; the rest is the unused code
    task automatic random_items(t_mix mix, int n, int hold_at);
        t_cmd             op_order [7];
        int               cut [7];
        int               r;
        logic [CMD_W-1:0] code;
        logic [POS_W-1:0] pos;
        op_order = '{CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT, CMD_READ,
                     CMD_POP_BACK, CMD_POP_FRONT, CMD_ERASE};
        case (mix)
            MIX_GROW:   cut = '{25, 45, 75, 85, 89, 93, 98};
            MIX_SHRINK: cut = '{8, 15, 22, 35, 55, 75, 98};
            default:    cut = '{14, 28, 43, 58, 70, 82, 97};
        endcase
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) hold_ticket <= hold_ticket + 1;
            r    = $urandom_range(0, 99);
            code = CMD_UNUSED;
            for (int k = 6; k >= 0; k--) begin
                if (r < cut[k]) code = op_order[k];
            end
            // mostly positions inside the list, some just past it, some anywhere
            case ($urandom_range(0, 19))
                17:      pos = POS_W'($urandom_range(0, 255));
                18:      pos = '1;
                19:      pos = POS_W'(list_count + 1);
                default: pos = POS_W'($urandom_range(0, list_count));
            endcase
            send_item(code, pos, $urandom());
            if (sender_idle_en && $urandom_range(0, 5) == 0) begin
                hold_sender($urandom_range(1, 10));
            end
        end
    endtask

    initial begin
        rst_n           <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.command  <= CMD_PUSH_BACK;
        cmd_ch.position <= '0;
        cmd_ch.value    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // errors on an empty list
        send_item(CMD_POP_BACK,  8'd0, 32'h0);
        send_item(CMD_POP_FRONT, 8'd0, 32'h0);
        send_item(CMD_ERASE,     8'd0, 32'h0);
        send_item(CMD_READ,      8'hFF, 32'h0);
        send_item(CMD_INSERT,    8'd1, 32'h1111_1111);
        // build a short list from both ends and the middle
        send_item(CMD_PUSH_BACK,  8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_PUSH_FRONT, 8'd0, 32'h0000_0000);
        send_item(CMD_INSERT,     8'd2, 32'h8000_0001);
        send_item(CMD_INSERT,     8'hFF, 32'hDEAD_BEEF);
        send_item(CMD_INSERT,     8'd1, 32'h1234_5678);
        send_item(CMD_READ,       8'd0, 32'h0);
        send_item(CMD_READ,       8'd3, 32'h0);
        send_item(CMD_READ,       8'd4, 32'h0);
        send_item(CMD_READ,       8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_ERASE,      8'hFF, 32'h0);
        send_item(CMD_ERASE,      8'd4, 32'h0);
        send_item(CMD_ERASE,      8'd1, 32'h0);
        send_item(CMD_READ,       8'd1, 32'h0);
        send_item(CMD_POP_FRONT,  8'd0, 32'h0);
        send_item(CMD_POP_BACK,   8'd0, 32'h0);
        send_item(CMD_UNUSED,     8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_READ,       8'd0, 32'h0);
        send_item(CMD_ERASE,      8'd0, 32'h0);
        send_item(CMD_READ,       8'd0, 32'h0);
        wait_drained();

        // fill past capacity with a long result stall early on
        random_items(MIX_GROW, 320, 60);
        wait_drained();
        random_items(MIX_EVEN, 100, 40);
        random_items(MIX_SHRINK, 230, -1);
        random_items(MIX_GROW, 40, -1);

        // closing stretch at full rate on both sides
        sender_idle_en = 1'b0;
        rsp_idle_en   <= 1'b0;
        random_items(MIX_EVEN, 60, -1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/pal_pkg.sv
design/pal_cmd_if.sv
design/pal_rsp_if.sv
design/pal_cell.sv
design/pal_ctrl.sv
design/positional_array_list_top.sv
bench/pal_list_checker.sv
bench/tb_positional_array_list_top.sv
